>>> design/dshot_erpm_telemetry_decoder_top_defines.svh
// Assertion macros for the checker file of the decoder.
`ifndef DSHOT_ERPM_TELEMETRY_DECODER_TOP_DEFINES_SVH
`define DSHOT_ERPM_TELEMETRY_DECODER_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define DSHOT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition implies another in the same cycle.
`define DSHOT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> design/dshot_pkg.sv
package dshot_pkg;

	// Result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BAD  = 2'd1;
	localparam logic [1:0] ST_STOP = 2'd2;
	localparam logic [1:0] ST_ZERO = 2'd3;

	localparam int FRAME_W  = 21;
	localparam int RPM_W    = 26;
	localparam int PERIOD_W = 16;
	localparam int PP_W     = 7;

	localparam logic [RPM_W-1:0]    ERPM_NUM   = 26'd60000000;
	localparam logic [RPM_W-1:0]    ERPM_OFS   = 26'd50;
	localparam logic [RPM_W-1:0]    RPM_ZERO   = 26'd1500;
	localparam logic [PP_W-1:0]     PP_RESET   = 7'd7;
	localparam logic [11:0]         VAL_STOP   = 12'hFFF;
	localparam logic [PERIOD_W-1:0] PERIOD_STOP = 16'd65408;

	// Pipeline depth: decode, 26 quotient bits, offset add, 26 quotient bits, output
	localparam int LATENCY = 55;

	// Side-band data that travels with each item through the dividers
	typedef struct packed {
		logic [1:0]          status;
		logic [PERIOD_W-1:0] period;
		logic [PP_W-1:0]     pp;
	} dshot_side_t;

	// GCR 5b/4b decode: bit 4 set marks an illegal code
	function automatic logic [4:0] gcr_decode(input logic [4:0] code);
		logic [4:0] r;
		unique case (code)
			5'h09: r = 5'h09;
			5'h0A: r = 5'h0A;
			5'h0B: r = 5'h0B;
			5'h0D: r = 5'h0D;
			5'h0E: r = 5'h0E;
			5'h0F: r = 5'h0F;
			5'h12: r = 5'h02;
			5'h13: r = 5'h03;
			5'h15: r = 5'h05;
			5'h16: r = 5'h06;
			5'h17: r = 5'h07;
			5'h19: r = 5'h00;
			5'h1A: r = 5'h08;
			5'h1B: r = 5'h01;
			5'h1D: r = 5'h04;
			5'h1E: r = 5'h0C;
			default: r = 5'h10;
		endcase
		return r;
	endfunction

endpackage

>>> design/dshot_erpm_telemetry_decoder_top.sv
// Frames on start pass decode, divider one, offset add and divider two to done.
// Throughput: one frame per cycle; busy stays low, the pipeline never stalls.
// The depth is set by two restoring dividers that resolve one quotient bit a stage.
// Results leave on a one-cycle done strobe; the receiver cannot stall.
// Reset clears all stage valid bits and loads pole_pairs with 7.
module dshot_erpm_telemetry_decoder_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [dshot_pkg::FRAME_W-1:0]     raw_frame,
	input  logic                              cfg_wr_en,
	input  logic [dshot_pkg::PP_W-1:0]        cfg_wr_data,
	output logic                              done,
	output logic [1:0]                        status,
	output logic [dshot_pkg::RPM_W-1:0]       rpm,
	output logic [dshot_pkg::PERIOD_W-1:0]    period_value
);
	import dshot_pkg::*;

	localparam int NB = RPM_W;

	logic [PP_W-1:0] pole_pairs_q;

	// Stage arrays: index 0 is the entry register of each divider
	logic              d1_vld_s  [0:NB];
	logic [NB-1:0]     d1_num_s  [0:NB];
	logic [PERIOD_W-1:0] d1_rem_s [0:NB];
	dshot_side_t       d1_side_s [0:NB];

	logic              d2_vld_s  [0:NB];
	logic [NB-1:0]     d2_num_s  [0:NB];
	logic [PP_W-1:0]   d2_rem_s  [0:NB];
	dshot_side_t       d2_side_s [0:NB];

	logic [19:0]        gcr;
	logic [15:0]        word;
	logic               bad;
	logic [3:0]         csum;
	logic [11:0]        val;
	logic [PERIOD_W-1:0] period;
	dshot_side_t        side_in;

	assign busy = 1'b0;

	// Hold the pole-pair register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_pairs_q <= PP_RESET;
		end else if (cfg_wr_en) begin
			pole_pairs_q <= cfg_wr_data;
		end
	end

	// Undo transition coding, decode GCR groups, check sum, expand period
	always_comb begin
		logic [4:0] dec;
		gcr  = 20'((raw_frame >> 1) ^ raw_frame);
		word = '0;
		bad  = 1'b0;
		for (int k = 0; k < 4; k++) begin
			dec = gcr_decode(gcr[5*k +: 5]);
			bad = bad | dec[4];
			word[4*k +: 4] = dec[3:0];
		end
		csum = word[15:12] ^ word[11:8] ^ word[7:4] ^ word[3:0];
		if (csum != 4'hF) begin
			bad = 1'b1;
		end
		val    = word[15:4];
		period = PERIOD_W'({7'd0, val[8:0]} << val[11:9]);
		side_in.period = period;
		side_in.pp     = (pole_pairs_q == '0) ? PP_W'(1) : pole_pairs_q;
		if (bad) begin
			side_in.status = ST_BAD;
		end else if (val == VAL_STOP) begin
			side_in.status = ST_STOP;
		end else if (val[8:0] == 9'd0) begin
			side_in.status = ST_ZERO;
		end else begin
			side_in.status = ST_OK;
		end
	end

	// Load the first divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_vld_s[0] <= 1'b0;
		end else begin
			d1_vld_s[0] <= start;
		end
	end

	always_ff @(posedge clk) begin
		d1_num_s[0]  <= ERPM_NUM;
		d1_rem_s[0]  <= '0;
		d1_side_s[0] <= side_in;
	end

	// First divider: 60000000 / period, one quotient bit a stage
	for (genvar i = 0; i < NB; i++) begin : g_div1
		logic [PERIOD_W:0] trial;
		logic [PERIOD_W:0] diff;
		logic              ge;

		always_comb begin
			trial = {d1_rem_s[i], d1_num_s[i][NB-1]};
			diff  = trial - {1'b0, d1_side_s[i].period};
			ge    = (trial >= {1'b0, d1_side_s[i].period});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d1_vld_s[i+1] <= 1'b0;
			end else begin
				d1_vld_s[i+1] <= d1_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			d1_rem_s[i+1]  <= ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
			d1_num_s[i+1]  <= {d1_num_s[i][NB-2:0], ge};
			d1_side_s[i+1] <= d1_side_s[i];
		end
	end

	// Add the offset and load the second divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d2_vld_s[0] <= 1'b0;
		end else begin
			d2_vld_s[0] <= d1_vld_s[NB];
		end
	end

	always_ff @(posedge clk) begin
		d2_num_s[0]  <= d1_num_s[NB] + ERPM_OFS;
		d2_rem_s[0]  <= '0;
		d2_side_s[0] <= d1_side_s[NB];
	end

	// Second divider: electrical rpm / pole pairs
	for (genvar i = 0; i < NB; i++) begin : g_div2
		logic [PP_W:0] trial;
		logic [PP_W:0] diff;
		logic          ge;

		always_comb begin
			trial = {d2_rem_s[i], d2_num_s[i][NB-1]};
			diff  = trial - {1'b0, d2_side_s[i].pp};
			ge    = (trial >= {1'b0, d2_side_s[i].pp});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d2_vld_s[i+1] <= 1'b0;
			end else begin
				d2_vld_s[i+1] <= d2_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			d2_rem_s[i+1]  <= ge ? diff[PP_W-1:0] : trial[PP_W-1:0];
			d2_num_s[i+1]  <= {d2_num_s[i][NB-2:0], ge};
			d2_side_s[i+1] <= d2_side_s[i];
		end
	end

	// Select the result fields by status and register them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= d2_vld_s[NB];
		end
	end

	always_ff @(posedge clk) begin
		status <= d2_side_s[NB].status;
		case (d2_side_s[NB].status)
			ST_OK: begin
				rpm          <= d2_num_s[NB];
				period_value <= d2_side_s[NB].period;
			end
			ST_STOP: begin
				rpm          <= '0;
				period_value <= d2_side_s[NB].period;
			end
			ST_ZERO: begin
				rpm          <= RPM_ZERO;
				period_value <= '0;
			end
			default: begin
				rpm          <= '0;
				period_value <= '0;
			end
		endcase
	end

endmodule

>>> design/dshot_chk.sv
`include "dshot_erpm_telemetry_decoder_top_defines.svh"

module dshot_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic [1:0]                     status,
	input logic [dshot_pkg::RPM_W-1:0]    rpm,
	input logic [dshot_pkg::PERIOD_W-1:0] period_value
);
	import dshot_pkg::*;

	// Every accepted frame gives its result after the fixed latency
	`DSHOT_ASSERT(a_latency, ((start && !busy) |-> ##LATENCY done), "result missing after latency")

	// Rejected frames carry no rpm and no period
	`DSHOT_IMPLY(a_bad_clear, done && status == ST_BAD, rpm == '0 && period_value == '0, "bad frame fields not cleared")

	// Stop code shows the fixed period and no rpm
	`DSHOT_IMPLY(a_stop, done && status == ST_STOP, rpm == '0 && period_value == PERIOD_STOP, "stop code fields wrong")

	// Zero period reports the fixed rpm; a valid reading is never zero rpm
	`DSHOT_IMPLY(a_zero, done && status == ST_ZERO, rpm == RPM_ZERO && period_value == '0, "zero period fields wrong")
	`DSHOT_IMPLY(a_ok_rpm, done && status == ST_OK, rpm != '0 && period_value != '0, "valid reading with zero field")

endmodule

bind dshot_erpm_telemetry_decoder_top dshot_chk u_dshot_chk (.*);
